### src/mrpt_pkg.sv
// Shared constants, types and codes for the Miller-Rabin prime test unit.
// No dependencies; every other file imports this package.
`default_nettype none

package mrpt_pkg;

  localparam int NUM_WIDTH   = 64;
  localparam int MUL_WIDTH   = (NUM_WIDTH > 32) ? NUM_WIDTH : 32;
  localparam int CAND_WIDTH  = 64;
  localparam int NUM_PRIMES  = 9;
  localparam int NUM_BASES   = 7;
  localparam int RES_WIDTH   = 5;
  localparam int BASE_WIDTH  = 31;
  localparam int DIGIT_WIDTH = 8;
  localparam int TRIAL_STEPS = (NUM_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
  localparam int TRIAL_WIDTH = TRIAL_STEPS * DIGIT_WIDTH;
  localparam int CNT_WIDTH   = $clog2(TRIAL_STEPS + 1);
  localparam int SHIFT_WIDTH = $clog2(NUM_WIDTH);
  localparam int IDX_WIDTH   = $clog2(NUM_BASES);
  localparam int MCNT_WIDTH  = $clog2(MUL_WIDTH + 1);

  typedef logic [NUM_WIDTH-1:0] num_t;
  typedef logic [MUL_WIDTH-1:0] mul_t;
  typedef logic [RES_WIDTH-1:0] res_t;

  localparam res_t SMALL_PRIMES [NUM_PRIMES] = '{
    5'd2, 5'd3, 5'd5, 5'd7, 5'd11, 5'd13, 5'd17, 5'd19, 5'd23
  };

  localparam logic [BASE_WIDTH-1:0] WITNESS_BASES [NUM_BASES] = '{
    31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
  };

  typedef enum logic [1:0] {
    MUL_BASE,
    MUL_RB,
    MUL_BB,
    MUL_XX
  } mul_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TRIAL,
    ST_TRIAL_CHK,
    ST_SPLIT,
    ST_BASE_START,
    ST_BASE_WAIT,
    ST_BASE_CHK,
    ST_POW_CHK,
    ST_POW_MUL_R,
    ST_POW_MUL_B,
    ST_POW_DONE,
    ST_SQ_CHK,
    ST_SQ_WAIT,
    ST_SQ_TEST,
    ST_NEXT_BASE,
    ST_FIN_PRIME,
    ST_FIN_COMP
  } state_t;

  typedef struct packed {
    logic    load_n;
    logic    trial_step;
    logic    split_init;
    logic    split_step;
    logic    base_init;
    logic    base_next;
    logic    pow_init;
    logic    mul_start;
    mul_op_t mul_op;
    logic    e_shift;
    logic    r_init;
    logic    r_inc;
    logic    out_load;
    logic    out_flag;
  } mrpt_cmd_t;

  typedef struct packed {
    logic trial_last;
    logic n_lt2;
    logic small_div;
    logic n_is_small;
    logic d_even;
    logic e_zero;
    logic e_lsb;
    logic b_zero;
    logic x_is_one;
    logic x_is_nm1;
    logic r_lt_s;
    logic last_base;
    logic mul_done;
    logic out_busy;
  } mrpt_sts_t;

endpackage

`default_nettype wire

### src/mrpt_if.sv
// Valid/ready channel interfaces for candidates and results.
// Depends on mrpt_pkg.
`default_nettype none

interface mrpt_in_if;
  import mrpt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CAND_WIDTH-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if;
  logic valid;
  logic ready;
  logic is_prime_flag;
  modport source (output valid, output is_prime_flag, input ready);
  modport sink   (input valid, input is_prime_flag, output ready);
endinterface

`default_nettype wire

### src/mrpt_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first,
// by modular doubling and conditional modular add. Depends on mrpt_pkg.
`default_nettype none

module mrpt_mulmod (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  mrpt_pkg::num_t    x,
  input  mrpt_pkg::mul_t    y,
  input  mrpt_pkg::num_t    n,
  output logic              done,
  output mrpt_pkg::num_t    prod
);
  import mrpt_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [MCNT_WIDTH-1:0] cnt_r;
  num_t                  acc_r;
  num_t                  x_r;
  mul_t                  y_r;
  num_t                  n_r;

  logic [NUM_WIDTH:0] dbl;
  logic [NUM_WIDTH:0] dbl_red;
  logic [NUM_WIDTH:0] sum;
  logic [NUM_WIDTH:0] sum_red;
  num_t               acc_nxt;
  logic               last;

  assign last = (cnt_r == MCNT_WIDTH'(1));

  always_comb begin
    dbl     = {1'b0, acc_r} + {1'b0, acc_r};
    dbl_red = (dbl >= {1'b0, n_r}) ? (dbl - {1'b0, n_r}) : dbl;
    sum     = {1'b0, dbl_red[NUM_WIDTH-1:0]} + {1'b0, x_r};
    sum_red = (sum >= {1'b0, n_r}) ? (sum - {1'b0, n_r}) : sum;
    acc_nxt = y_r[MUL_WIDTH-1] ? sum_red[NUM_WIDTH-1:0] : dbl_red[NUM_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MCNT_WIDTH'(MUL_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MCNT_WIDTH'(1);
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      x_r   <= x;
      y_r   <= y;
      n_r   <= n;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[MUL_WIDTH-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

### src/mrpt_datapath.sv
// Datapath: candidate, trial-division residues, d/s split, exponent, base
// and witness registers, result register, and the modular multiplier.
// Depends on mrpt_pkg and mrpt_mulmod.
`default_nettype none

module mrpt_datapath (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire [mrpt_pkg::CAND_WIDTH-1:0] candidate,
  input  mrpt_pkg::mrpt_cmd_t       cmd,
  input  wire                       out_ready,
  output mrpt_pkg::mrpt_sts_t       sts,
  output logic                      out_valid,
  output logic                      out_flag
);
  import mrpt_pkg::*;

  num_t                   n_r;
  num_t                   d_r;
  num_t                   e_r;
  num_t                   b_r;
  num_t                   x_r;
  logic [TRIAL_WIDTH-1:0] t_r;
  logic [SHIFT_WIDTH-1:0] s_r;
  logic [SHIFT_WIDTH-1:0] r_r;
  logic [IDX_WIDTH-1:0]   idx_r;
  logic [CNT_WIDTH-1:0]   tcnt_r;
  res_t                   res_r [NUM_PRIMES];
  res_t                   res_nxt [NUM_PRIMES];
  mul_op_t                op_r;
  logic                   out_valid_r;
  logic                   out_flag_r;

  num_t  mul_x;
  mul_t  mul_y;
  logic  mul_done;
  num_t  mul_prod;
  logic  any_zero;
  logic  any_eq;
  logic  [RES_WIDTH:0] twice;
  res_t  rem;

  // one digit of the candidate per cycle, MSB first, into every residue
  always_comb begin
    for (int i = 0; i < NUM_PRIMES; i++) begin
      rem = res_r[i];
      for (int j = 0; j < DIGIT_WIDTH; j++) begin
        twice = {rem, t_r[TRIAL_WIDTH-1-j]};
        rem   = (twice >= {1'b0, SMALL_PRIMES[i]}) ?
                RES_WIDTH'(twice - {1'b0, SMALL_PRIMES[i]}) : RES_WIDTH'(twice);
      end
      res_nxt[i] = rem;
    end
  end

  always_comb begin
    any_zero = 1'b0;
    any_eq   = 1'b0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (res_r[i] == '0) begin
        any_zero = 1'b1;
      end
      if (n_r == NUM_WIDTH'(SMALL_PRIMES[i])) begin
        any_eq = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.mul_op)
      MUL_BASE: begin
        mul_x = NUM_WIDTH'(1);
        mul_y = MUL_WIDTH'(WITNESS_BASES[idx_r]);
      end
      MUL_RB: begin
        mul_x = x_r;
        mul_y = MUL_WIDTH'(b_r);
      end
      MUL_BB: begin
        mul_x = b_r;
        mul_y = MUL_WIDTH'(b_r);
      end
      MUL_XX: begin
        mul_x = x_r;
        mul_y = MUL_WIDTH'(x_r);
      end
      default: begin
        mul_x = x_r;
        mul_y = MUL_WIDTH'(x_r);
      end
    endcase
  end

  mrpt_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .n     (n_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n_r    <= candidate[NUM_WIDTH-1:0];
      t_r    <= TRIAL_WIDTH'(candidate[NUM_WIDTH-1:0]);
      tcnt_r <= CNT_WIDTH'(TRIAL_STEPS);
      for (int i = 0; i < NUM_PRIMES; i++) begin
        res_r[i] <= '0;
      end
    end else if (cmd.trial_step) begin
      t_r    <= {t_r[TRIAL_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
      tcnt_r <= tcnt_r - CNT_WIDTH'(1);
      for (int i = 0; i < NUM_PRIMES; i++) begin
        res_r[i] <= res_nxt[i];
      end
    end else if (cmd.split_init) begin
      d_r <= n_r - NUM_WIDTH'(1);
      s_r <= '0;
    end else if (cmd.split_step) begin
      d_r <= {1'b0, d_r[NUM_WIDTH-1:1]};
      s_r <= s_r + SHIFT_WIDTH'(1);
    end

    if (cmd.base_init) begin
      idx_r <= '0;
    end else if (cmd.base_next) begin
      idx_r <= idx_r + IDX_WIDTH'(1);
    end

    if (cmd.r_init) begin
      r_r <= SHIFT_WIDTH'(1);
    end else if (cmd.r_inc) begin
      r_r <= r_r + SHIFT_WIDTH'(1);
    end

    if (cmd.pow_init) begin
      e_r <= d_r;
    end else if (cmd.e_shift) begin
      e_r <= {1'b0, e_r[NUM_WIDTH-1:1]};
    end

    if (cmd.mul_start) begin
      op_r <= cmd.mul_op;
    end

    if (cmd.pow_init) begin
      x_r <= NUM_WIDTH'(1);
    end else if (mul_done) begin
      unique case (op_r)
        MUL_BASE: b_r <= mul_prod;
        MUL_RB:   x_r <= mul_prod;
        MUL_BB:   b_r <= mul_prod;
        MUL_XX:   x_r <= mul_prod;
        default:  x_r <= mul_prod;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_flag_r <= cmd.out_flag;
    end
  end

  always_comb begin
    sts.trial_last = (tcnt_r == CNT_WIDTH'(1));
    sts.n_lt2      = (n_r < NUM_WIDTH'(2));
    sts.small_div  = any_zero;
    sts.n_is_small = any_eq;
    sts.d_even     = !d_r[0];
    sts.e_zero     = (e_r == '0);
    sts.e_lsb      = e_r[0];
    sts.b_zero     = (b_r == '0);
    sts.x_is_one   = (x_r == NUM_WIDTH'(1));
    sts.x_is_nm1   = (x_r == n_r - NUM_WIDTH'(1));
    sts.r_lt_s     = (r_r < s_r);
    sts.last_base  = (idx_r == IDX_WIDTH'(NUM_BASES - 1));
    sts.mul_done   = mul_done;
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_flag  = out_flag_r;

endmodule

`default_nettype wire

### src/mrpt_ctrl.sv
// Controller state machine sequencing trial division, the d/s split and the
// witness rounds. Depends on mrpt_pkg.
`default_nettype none

module mrpt_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  mrpt_pkg::mrpt_sts_t  sts,
  output logic                 in_ready,
  output mrpt_pkg::mrpt_cmd_t  cmd
);
  import mrpt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_TRIAL;
      end
      ST_TRIAL: begin
        if (sts.trial_last) state_nxt = ST_TRIAL_CHK;
      end
      ST_TRIAL_CHK: begin
        priority if (sts.n_lt2) state_nxt = ST_FIN_COMP;
        else if (sts.small_div) state_nxt = sts.n_is_small ? ST_FIN_PRIME : ST_FIN_COMP;
        else state_nxt = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (!sts.d_even) state_nxt = ST_BASE_START;
      end
      ST_BASE_START: state_nxt = ST_BASE_WAIT;
      ST_BASE_WAIT: begin
        if (sts.mul_done) state_nxt = ST_BASE_CHK;
      end
      ST_BASE_CHK: state_nxt = sts.b_zero ? ST_NEXT_BASE : ST_POW_CHK;
      ST_POW_CHK: begin
        priority if (sts.e_zero) state_nxt = ST_POW_DONE;
        else if (sts.e_lsb) state_nxt = ST_POW_MUL_R;
        else state_nxt = ST_POW_MUL_B;
      end
      ST_POW_MUL_R: begin
        if (sts.mul_done) state_nxt = ST_POW_MUL_B;
      end
      ST_POW_MUL_B: begin
        if (sts.mul_done) state_nxt = ST_POW_CHK;
      end
      ST_POW_DONE: begin
        state_nxt = (sts.x_is_one || sts.x_is_nm1) ? ST_NEXT_BASE : ST_SQ_CHK;
      end
      ST_SQ_CHK: state_nxt = sts.r_lt_s ? ST_SQ_WAIT : ST_FIN_COMP;
      ST_SQ_WAIT: begin
        if (sts.mul_done) state_nxt = ST_SQ_TEST;
      end
      ST_SQ_TEST: state_nxt = sts.x_is_nm1 ? ST_NEXT_BASE : ST_SQ_CHK;
      ST_NEXT_BASE: state_nxt = sts.last_base ? ST_FIN_PRIME : ST_BASE_START;
      ST_FIN_PRIME: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      ST_FIN_COMP: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_BASE;
    in_ready   = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE:       cmd.load_n = in_valid;
      ST_TRIAL:      cmd.trial_step = 1'b1;
      ST_TRIAL_CHK:  cmd.split_init = !sts.n_lt2 && !sts.small_div;
      ST_SPLIT: begin
        cmd.split_step = sts.d_even;
        cmd.base_init  = !sts.d_even;
      end
      ST_BASE_START: cmd.mul_start = 1'b1;
      ST_BASE_WAIT:  cmd.mul_op = MUL_BASE;
      ST_BASE_CHK:   cmd.pow_init = !sts.b_zero;
      ST_POW_CHK: begin
        cmd.mul_start = !sts.e_zero;
        cmd.mul_op    = sts.e_lsb ? MUL_RB : MUL_BB;
      end
      ST_POW_MUL_R: begin
        cmd.mul_start = sts.mul_done;
        cmd.mul_op    = MUL_BB;
      end
      ST_POW_MUL_B:  cmd.e_shift = sts.mul_done;
      ST_POW_DONE:   cmd.r_init = !(sts.x_is_one || sts.x_is_nm1);
      ST_SQ_CHK: begin
        cmd.mul_start = sts.r_lt_s;
        cmd.mul_op    = MUL_XX;
      end
      ST_SQ_WAIT:    cmd.r_inc = sts.mul_done;
      ST_SQ_TEST:    cmd.mul_op = MUL_XX;
      ST_NEXT_BASE:  cmd.base_next = !sts.last_base;
      ST_FIN_PRIME: begin
        cmd.out_load = !sts.out_busy;
        cmd.out_flag = 1'b1;
      end
      ST_FIN_COMP: begin
        cmd.out_load = !sts.out_busy;
        cmd.out_flag = 1'b0;
      end
      default: cmd.mul_op = MUL_BASE;
    endcase
  end

endmodule

`default_nettype wire

### src/miller_rabin_prime_test_unit.sv
// Miller-Rabin prime test unit, 64-bit deterministic, one candidate at a time.
// The result comes straight from trial division when that settles it, else after
// the witness rounds, with each modular product formed by the bit-serial multiplier.
// The next candidate is taken once a result is parked in the output register.
// Synchronous active-low reset clears control.
`default_nettype none

module miller_rabin_prime_test_unit (
  input wire          clk,
  input wire          rst_n,
  mrpt_in_if.sink     in_chan,
  mrpt_out_if.source  out_chan
);
  import mrpt_pkg::*;

  mrpt_cmd_t cmd;
  mrpt_sts_t sts;

  mrpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .sts      (sts),
    .in_ready (in_chan.ready),
    .cmd      (cmd)
  );

  mrpt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .candidate (in_chan.candidate),
    .cmd       (cmd),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .out_valid (out_chan.valid),
    .out_flag  (out_chan.is_prime_flag)
  );

endmodule

`default_nettype wire
